[design/lfd_pkg.sv]
// Package: shared types and constants for the LED flash and delay controller.
package lfd_pkg;

    localparam int NUM_LEDS_DEF    = 4;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int LED_MAX         = 8;
    localparam int CNT_MAX         = 32;

    localparam int FUNC_W    = 3;
    localparam int INDEX_W   = 3;
    localparam int CTRL_W    = 2;
    localparam int DELAY_W   = 16;
    localparam int PATTERN_W = 4;
    localparam int LED_OUT_W = 4;

    localparam int IN_BITS  = FUNC_W + INDEX_W + 2 * CTRL_W + 1 + DELAY_W + PATTERN_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = LED_OUT_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK       = 3'd0,
        FUNC_SET_LED    = 3'd1,
        FUNC_DELAY_SET  = 3'd2,
        FUNC_DELAY_STOP = 3'd3,
        FUNC_SET_ALL    = 3'd4
    } func_t;

    localparam logic [CTRL_W-1:0] CTRL_KEEP = 2'd0;
    localparam logic [CTRL_W-1:0] CTRL_OFF  = 2'd1;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [DELAY_W-1:0]   delay_ticks;
        logic                 start_on;
        logic [CTRL_W-1:0]    flash_ctrl;
        logic [CTRL_W-1:0]    on_ctrl;
        logic [INDEX_W-1:0]   led_index;
        func_t                func;
    } item_t;

    typedef struct packed {
        logic [LED_OUT_W-1:0] led_on;
        logic                 updated;
    } result_t;

endpackage

[design/lfd_core.sv]
// LED state registers, countdowns and the per-item update logic.
module lfd_core #(
    parameter int NUM_LEDS    = lfd_pkg::NUM_LEDS_DEF,
    parameter int COUNT_WIDTH = lfd_pkg::COUNT_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  lfd_pkg::item_t  item,
    output lfd_pkg::result_t result
);

    logic [NUM_LEDS-1:0]    steady_reg, steady_next;
    logic [NUM_LEDS-1:0]    flash_reg, flash_next;
    logic [NUM_LEDS-1:0]    lit_reg, lit_next;
    logic                   force_reg, force_next;
    logic [NUM_LEDS-1:0]    snap_reg, snap_next;
    logic [NUM_LEDS-1:0]    tog_arm_reg, tog_arm_next;
    logic [NUM_LEDS-1:0]    unf_arm_reg, unf_arm_next;
    logic [COUNT_WIDTH-1:0] cnt_reg [NUM_LEDS];
    logic [COUNT_WIDTH-1:0] cnt_next [NUM_LEDS];

    logic [NUM_LEDS-1:0]          sel;
    logic                         idx_ok;
    logic [lfd_pkg::CNT_MAX-1:0]  dly_ext;
    logic [lfd_pkg::LED_MAX-1:0]  pat_ext;
    logic [lfd_pkg::LED_MAX-1:0]  lit_ext;
    logic                         upd;

    assign idx_ok  = {1'b0, item.led_index} < 4'(NUM_LEDS);
    assign dly_ext = lfd_pkg::CNT_MAX'(item.delay_ticks);
    assign pat_ext = lfd_pkg::LED_MAX'(item.pattern);

    always_comb
    begin
        for (int n = 0; n < NUM_LEDS; n++)
        begin
            sel[n] = idx_ok && (item.led_index == lfd_pkg::INDEX_W'(n));
        end
    end

    always_comb
    begin
        steady_next  = steady_reg;
        flash_next   = flash_reg;
        lit_next     = lit_reg;
        force_next   = force_reg;
        snap_next    = snap_reg;
        tog_arm_next = tog_arm_reg;
        unf_arm_next = unf_arm_reg;
        cnt_next     = cnt_reg;
        upd          = 1'b0;
        unique case (item.func)
            lfd_pkg::FUNC_TICK:
            begin
                for (int n = 0; n < NUM_LEDS; n++)
                begin
                    if (cnt_reg[n] != '0)
                    begin
                        cnt_next[n] = cnt_reg[n] - 1'b1;
                    end
                    if (tog_arm_reg[n] && (steady_reg[n] != snap_reg[n])
                        && (cnt_next[n] == '0))
                    begin
                        steady_next[n]  = ~steady_reg[n];
                        tog_arm_next[n] = 1'b0;
                        force_next      = 1'b1;
                    end
                    if (unf_arm_reg[n] && flash_reg[n] && (cnt_next[n] == '0))
                    begin
                        flash_next[n]   = 1'b0;
                        unf_arm_next[n] = 1'b0;
                        force_next      = 1'b1;
                    end
                end
                if (force_next || (flash_next != '0))
                begin
                    force_next = 1'b0;
                    lit_next   = (~lit_reg & flash_next) | (steady_next & ~flash_next);
                    upd        = 1'b1;
                end
            end
            lfd_pkg::FUNC_SET_LED:
            begin
                if (idx_ok)
                begin
                    if (item.on_ctrl == lfd_pkg::CTRL_OFF)
                    begin
                        steady_next = steady_reg & ~sel;
                    end
                    else if (item.on_ctrl != lfd_pkg::CTRL_KEEP)
                    begin
                        steady_next = steady_reg | sel;
                    end
                    if (item.flash_ctrl == lfd_pkg::CTRL_OFF)
                    begin
                        flash_next = flash_reg & ~sel;
                    end
                    else if (item.flash_ctrl != lfd_pkg::CTRL_KEEP)
                    begin
                        flash_next = flash_reg | sel;
                    end
                    force_next = 1'b1;
                end
            end
            lfd_pkg::FUNC_DELAY_SET:
            begin
                if (idx_ok)
                begin
                    for (int n = 0; n < NUM_LEDS; n++)
                    begin
                        if (sel[n])
                        begin
                            cnt_next[n] = dly_ext[COUNT_WIDTH-1:0];
                        end
                    end
                    steady_next  = item.start_on ? (steady_reg | sel) : (steady_reg & ~sel);
                    snap_next    = ~steady_next;
                    tog_arm_next = tog_arm_reg | sel;
                    flash_next   = flash_reg & ~sel;
                    force_next   = 1'b1;
                end
            end
            lfd_pkg::FUNC_DELAY_STOP:
            begin
                if (idx_ok)
                begin
                    for (int n = 0; n < NUM_LEDS; n++)
                    begin
                        if (sel[n])
                        begin
                            cnt_next[n] = dly_ext[COUNT_WIDTH-1:0];
                        end
                    end
                    unf_arm_next = unf_arm_reg | sel;
                    flash_next   = flash_reg | sel;
                    force_next   = 1'b1;
                end
            end
            lfd_pkg::FUNC_SET_ALL:
            begin
                steady_next = pat_ext[NUM_LEDS-1:0];
                force_next  = 1'b1;
            end
            default:
            begin
                upd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steady_reg  <= '0;
            flash_reg   <= '0;
            lit_reg     <= '0;
            force_reg   <= 1'b1;
            snap_reg    <= '0;
            tog_arm_reg <= '0;
            unf_arm_reg <= '0;
            for (int n = 0; n < NUM_LEDS; n++)
            begin
                cnt_reg[n] <= '0;
            end
        end
        else if (step)
        begin
            steady_reg  <= steady_next;
            flash_reg   <= flash_next;
            lit_reg     <= lit_next;
            force_reg   <= force_next;
            snap_reg    <= snap_next;
            tog_arm_reg <= tog_arm_next;
            unf_arm_reg <= unf_arm_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign lit_ext        = lfd_pkg::LED_MAX'(lit_next);
    assign result.led_on  = lit_ext[lfd_pkg::LED_OUT_W-1:0];
    assign result.updated = upd;

endmodule

[design/led_flash_delay_controller.sv]
// Top level: LED flash and delay controller with stream input and output channels.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one item: a tick or an LED command.
//   m_tvalid/m_tready/m_tdata carry one result per item: the lit state of the
//   LEDs after that item and a flag telling whether the item recomputed it.
// Path: an accepted item is held in the input register; its result is computed
//   from that register and lands in the output register, valid to the receiver
//   from then on.
// Throughput: one item per cycle while m_tready is high; the LED state update is a
//   single pass of bit logic plus one countdown decrement per LED between registers.
// Stall: while the receiver holds m_tready low, the result stays in place;
//   an empty input register still takes one more item, then s_tready stays low
//   until the receiver raises m_tready.
// Reset: all LEDs off, no flashing, countdowns cleared and both registers
//   empty; the first tick after reset always recomputes the lit state.
module led_flash_delay_controller #(
    parameter int NUM_LEDS    = lfd_pkg::NUM_LEDS_DEF,
    parameter int COUNT_WIDTH = lfd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // func[2:0], led_index[5:3], on_ctrl[7:6], flash_ctrl[9:8], start_on[10],
    // delay_ticks[26:11], pattern[30:27], zero[31]
    input  logic [lfd_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // led_on[3:0], updated[4], zero[7:5]
    output logic [lfd_pkg::OUT_W-1:0] m_tdata
);

    logic             in_valid_reg;
    lfd_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    lfd_pkg::result_t out_data_reg;
    lfd_pkg::result_t result;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= lfd_pkg::item_t'(s_tdata[lfd_pkg::IN_BITS-1:0]);
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    lfd_core #(
        .NUM_LEDS    (NUM_LEDS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lfd_pkg::OUT_W - lfd_pkg::OUT_BITS){1'b0}},
                       out_data_reg.updated, out_data_reg.led_on};

endmodule
